// File: src/lgp_pkg.sv
// ----------------------------------------------------------------------------
// lgp_pkg: shared types and constants for the linear gradient pixel block
// Register map codes, configuration bundle, reset values and the helper
// that picks one packed RGBA stop word out of the two stop registers.
// ----------------------------------------------------------------------------
`default_nettype none

package lgp_pkg;

	// Gradient limits
	localparam int MAX_STOPS = 4;
	localparam int MAX_DIM   = 4096;

	// APB register port geometry: 64-bit registers on 8-byte strides
	localparam int LGP_DATA_W = 64;
	localparam int LGP_ADDR_W = 6;
	localparam int LGP_IDX_LSB = 3;

	// Register indexes
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_COS_A        = 3'd2;
	localparam logic [2:0] REG_SIN_A        = 3'd3;
	localparam logic [2:0] REG_INV_SPAN     = 3'd4;
	localparam logic [2:0] REG_NUM_STOPS    = 3'd5;
	localparam logic [2:0] REG_STOPS_LO     = 3'd6;
	localparam logic [2:0] REG_STOPS_HI     = 3'd7;

	// Reset values
	localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd256;
	localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd256;
	localparam logic [15:0] RST_COS_A        = 16'h4000;
	localparam logic [15:0] RST_SIN_A        = 16'h0000;
	localparam logic [23:0] RST_INV_SPAN     = 24'd46341;
	localparam logic [2:0]  RST_NUM_STOPS    = 3'd2;

	// Distance scale: Q16, one half and one
	localparam logic [16:0] DIST_HALF = 17'd32768;
	localparam logic [16:0] DIST_ONE  = 17'd65536;

	typedef struct packed {
		logic        [12:0] image_width;
		logic        [12:0] image_height;
		logic signed [15:0] cos_a;
		logic signed [15:0] sin_a;
		logic        [23:0] inv_span;
		logic        [2:0]  num_stops;
		logic        [63:0] stops_lo;
		logic        [63:0] stops_hi;
	} lgp_cfg_t;

	// Select stop word k (0..3) from the packed stop registers
	function automatic logic [31:0] stop_word(input logic [63:0] lo, input logic [63:0] hi,
			input logic [1:0] k);
		logic [63:0] pair;
		begin
			pair = k[1] ? hi : lo;
			stop_word = k[0] ? pair[63:32] : pair[31:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: src/lgp_pix_if.sv
// ----------------------------------------------------------------------------
// lgp_pix_if: pixel coordinate request channel
// Valid/ready channel carrying one pixel column and row per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgp_pix_if;
	logic        valid;
	logic        ready;
	logic [11:0] pix_x;
	logic [11:0] pix_y;

	modport source (output valid, output pix_x, output pix_y, input ready);
	modport sink   (input valid, input pix_x, input pix_y, output ready);
endinterface

`default_nettype wire

// File: src/lgp_rgba_if.sv
// ----------------------------------------------------------------------------
// lgp_rgba_if: colored pixel result channel
// Valid/ready channel carrying the coordinate and its RGBA color.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgp_rgba_if;
	logic        valid;
	logic        ready;
	logic [11:0] out_x;
	logic [11:0] out_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;

	modport source (output valid, output out_x, output out_y, output red, output green,
		output blue, output alpha, input ready);
	modport sink   (input valid, input out_x, input out_y, input red, input green,
		input blue, input alpha, output ready);
endinterface

`default_nettype wire

// File: src/lgp_regs.sv
// ----------------------------------------------------------------------------
// lgp_regs: APB configuration registers
// Holds the gradient geometry, reciprocal span, stop count and stop colors.
// Writes land on the access cycle; reads return the stored value.
// ----------------------------------------------------------------------------
`default_nettype none

module lgp_regs
	import lgp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [LGP_ADDR_W-1:0] paddr,
	input  wire logic [LGP_DATA_W-1:0] pwdata,
	output logic      [LGP_DATA_W-1:0] prdata,
	output logic                       pready,
	output lgp_cfg_t                   cfg
);

	lgp_cfg_t   cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[LGP_ADDR_W-1:LGP_IDX_LSB];
	assign cfg     = cfg_q;

	// Write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_IMAGE_WIDTH;
			cfg_q.image_height <= RST_IMAGE_HEIGHT;
			cfg_q.cos_a        <= RST_COS_A;
			cfg_q.sin_a        <= RST_SIN_A;
			cfg_q.inv_span     <= RST_INV_SPAN;
			cfg_q.num_stops    <= RST_NUM_STOPS;
			cfg_q.stops_lo     <= '0;
			cfg_q.stops_hi     <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[12:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[12:0];
				REG_COS_A:        cfg_q.cos_a        <= pwdata[15:0];
				REG_SIN_A:        cfg_q.sin_a        <= pwdata[15:0];
				REG_INV_SPAN:     cfg_q.inv_span     <= pwdata[23:0];
				REG_NUM_STOPS:    cfg_q.num_stops    <= pwdata[2:0];
				REG_STOPS_LO:     cfg_q.stops_lo     <= pwdata;
				REG_STOPS_HI:     cfg_q.stops_hi     <= pwdata;
				default:          ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH:  prdata = {51'd0, cfg_q.image_width};
			REG_IMAGE_HEIGHT: prdata = {51'd0, cfg_q.image_height};
			REG_COS_A:        prdata = {48'd0, cfg_q.cos_a};
			REG_SIN_A:        prdata = {48'd0, cfg_q.sin_a};
			REG_INV_SPAN:     prdata = {40'd0, cfg_q.inv_span};
			REG_NUM_STOPS:    prdata = {61'd0, cfg_q.num_stops};
			REG_STOPS_LO:     prdata = cfg_q.stops_lo;
			REG_STOPS_HI:     prdata = cfg_q.stops_hi;
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: src/linear_gradient_pixel_top.sv
// ----------------------------------------------------------------------------
// linear_gradient_pixel_top: multi-stop linear gradient pixel generator
// Maps each pixel coordinate to an RGBA color on a 2..4 stop linear gradient.
// ----------------------------------------------------------------------------
// Usage: the block takes one pixel request per clock and returns it with its
// color; throughput is one pixel per cycle as long as the result side takes
// results. The seven stages are centering, the two direction products, their
// sum, the reciprocal-span product, distance rounding and clamp, stop
// selection, and per-channel blending. Each stage holds its data only while
// the stage after it is full and stalled, so bubbles close up under
// back-pressure. Program the registers over APB (8-byte stride) only while no
// pixel is in flight; the pipeline reads them live.
`default_nettype none

module linear_gradient_pixel_top
	import lgp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	lgp_pix_if.sink                    pix,
	lgp_rgba_if.source                 rgba,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [LGP_ADDR_W-1:0] paddr,
	input  wire logic [LGP_DATA_W-1:0] pwdata,
	output logic      [LGP_DATA_W-1:0] prdata,
	output logic                       pready
);

	lgp_cfg_t cfg;

	lgp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ------------------------------------------------------------------
	// Stage enables: a stage loads when it is empty or its successor loads
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = ~valid_s7 | rgba.ready;
	assign en6 = ~valid_s6 | en7;
	assign en5 = ~valid_s5 | en6;
	assign en4 = ~valid_s4 | en5;
	assign en3 = ~valid_s3 | en4;
	assign en2 = ~valid_s2 | en3;
	assign en1 = ~valid_s1 | en2;
	assign pix.ready = en1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= pix.valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
			if (en7) valid_s7 <= valid_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: doubled centered offsets
	// ------------------------------------------------------------------
	logic        [12:0] width_c, height_c;
	logic        [11:0] x_s1, y_s1;
	logic signed [13:0] dx2_s1, dy2_s1;

	assign width_c  = (32'(cfg.image_width) > MAX_DIM) ? 13'(MAX_DIM) : cfg.image_width;
	assign height_c = (32'(cfg.image_height) > MAX_DIM) ? 13'(MAX_DIM) : cfg.image_height;

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1   <= pix.pix_x;
			y_s1   <= pix.pix_y;
			dx2_s1 <= $signed({1'b0, pix.pix_x, 1'b0}) - $signed({1'b0, width_c});
			dy2_s1 <= $signed({1'b0, pix.pix_y, 1'b0}) - $signed({1'b0, height_c});
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: direction products
	// ------------------------------------------------------------------
	logic        [11:0] x_s2, y_s2;
	logic signed [29:0] pc_s2, ps_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			pc_s2 <= dx2_s1 * cfg.cos_a;
			ps_s2 <= dy2_s1 * cfg.sin_a;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: projection sum
	// ------------------------------------------------------------------
	logic        [11:0] x_s3, y_s3;
	logic signed [30:0] proj_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			proj_s3 <= 31'(pc_s2) + 31'(ps_s2);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: scale by the reciprocal span
	// ------------------------------------------------------------------
	logic        [11:0] x_s4, y_s4;
	logic signed [55:0] prod_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			prod_s4 <= proj_s3 * $signed({1'b0, cfg.inv_span});
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: floor to Q16, add one half, clamp to 0..1
	// ------------------------------------------------------------------
	logic        [11:0] x_s5, y_s5;
	logic        [16:0] dist_s5;
	logic signed [33:0] dist_raw;
	logic        [16:0] dist_c;

	assign dist_raw = $signed({prod_s4[55], prod_s4[55:23]}) + $signed({17'd0, DIST_HALF});

	always_comb begin
		if (dist_raw < 0) begin
			dist_c = '0;
		end else if (dist_raw > $signed({17'd0, DIST_ONE})) begin
			dist_c = DIST_ONE;
		end else begin
			dist_c = dist_raw[16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			x_s5    <= x_s4;
			y_s5    <= y_s4;
			dist_s5 <= dist_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: stop index and fraction, pick the two bracketing stops
	// ------------------------------------------------------------------
	logic [2:0]  n_stops;
	logic [1:0]  n_m1;
	logic [18:0] scaled;
	logic [2:0]  seg_idx;
	logic        at_last;
	logic [11:0] x_s6, y_s6;
	logic [15:0] frac_s6;
	logic [31:0] ca_s6, cb_s6;

	// Hold the stop count within 2..MAX_STOPS
	always_comb begin
		if (cfg.num_stops < 3'd2) begin
			n_stops = 3'd2;
		end else if (32'(cfg.num_stops) > MAX_STOPS) begin
			n_stops = 3'(MAX_STOPS);
		end else begin
			n_stops = cfg.num_stops;
		end
	end

	assign n_m1    = 2'(n_stops - 3'd1);
	assign scaled  = 19'(dist_s5) * 19'(n_m1);
	assign seg_idx = scaled[18:16];
	assign at_last = seg_idx >= {1'b0, n_m1};

	// At distance one, blend the last stop with itself at zero fraction
	always_ff @(posedge clk) begin
		if (en6) begin
			x_s6 <= x_s5;
			y_s6 <= y_s5;
			if (at_last) begin
				ca_s6   <= stop_word(cfg.stops_lo, cfg.stops_hi, n_m1);
				cb_s6   <= stop_word(cfg.stops_lo, cfg.stops_hi, n_m1);
				frac_s6 <= '0;
			end else begin
				ca_s6   <= stop_word(cfg.stops_lo, cfg.stops_hi, seg_idx[1:0]);
				cb_s6   <= stop_word(cfg.stops_lo, cfg.stops_hi, seg_idx[1:0] + 2'd1);
				frac_s6 <= scaled[15:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: per-channel blend with floor rounding
	// ------------------------------------------------------------------
	logic [11:0] x_s7, y_s7;
	logic [31:0] color_s7;
	logic [31:0] color_c;

	always_comb begin
		logic        [7:0]  ca, cb;
		logic signed [8:0]  diff;
		logic signed [25:0] acc;
		color_c = '0;
		for (int ch = 0; ch < 4; ch++) begin
			ca   = ca_s6[8*ch +: 8];
			cb   = cb_s6[8*ch +: 8];
			diff = $signed({1'b0, cb}) - $signed({1'b0, ca});
			acc  = $signed({2'b00, ca, 16'd0}) + 26'($signed({1'b0, frac_s6}) * diff);
			color_c[8*ch +: 8] = acc[23:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			x_s7     <= x_s6;
			y_s7     <= y_s6;
			color_s7 <= color_c;
		end
	end

	assign rgba.valid = valid_s7;
	assign rgba.out_x = x_s7;
	assign rgba.out_y = y_s7;
	assign rgba.red   = color_s7[7:0];
	assign rgba.green = color_s7[15:8];
	assign rgba.blue  = color_s7[23:16];
	assign rgba.alpha = color_s7[31:24];

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_dist_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> dist_s5 <= DIST_ONE)
		else $error("distance outside 0..1");

	a_seg_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> seg_idx <= {1'b0, n_m1})
		else $error("stop index beyond last stop");

	a_last_no_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && at_last) |-> scaled[15:0] == 16'd0)
		else $error("nonzero fraction at last stop");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5
			&& valid_s6 && valid_s7 && !rgba.ready))
		else $error("input stalled with a bubble in the pipeline");

endmodule

`default_nettype wire

// File: dv/gradient_color_checker.sv
// ----------------------------------------------------------------------------
// gradient_color_checker: color prediction and result checking
// Watches the pixel request channel, the color result channel and the APB
// register port. Keeps its own copy of the gradient registers, works out the
// color of every accepted pixel request and compares each returned color,
// field by field, with the oldest outstanding prediction. Register reads are
// checked against the tracked register copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module gradient_color_checker
	import lgp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	lgp_pix_if                         pix,
	lgp_rgba_if                        rgba,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic                  pready,
	input  wire logic [LGP_ADDR_W-1:0] paddr,
	input  wire logic [LGP_DATA_W-1:0] pwdata,
	input  wire logic [LGP_DATA_W-1:0] prdata,
	output int                         fault_count,
	output int                         colors_pending,
	output int                         colors_checked
);

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
	} pixel_color_t;

	lgp_cfg_t     regs;
	pixel_color_t colors_due[$];
	int           faults;
	int           checked;

	// Pick one packed RGBA stop out of the tracked stop registers
	function automatic logic [31:0] stop_color(input int k);
		case (k)
			0: return regs.stops_lo[31:0];
			1: return regs.stops_lo[63:32];
			2: return regs.stops_hi[31:0];
			default: return regs.stops_hi[63:32];
		endcase
	endfunction

	// Work out the gradient color of one pixel from the tracked registers
	function automatic pixel_color_t gradient_color(input logic [11:0] px, input logic [11:0] py);
		longint       span_w;
		longint       span_h;
		longint       proj;
		longint       distance;
		longint       scaled;
		longint       frac;
		longint       lo_c;
		longint       hi_c;
		longint       acc;
		int           n;
		int           idx;
		logic [31:0]  near;
		logic [31:0]  far;
		logic [31:0]  mix;
		pixel_color_t c;
		span_w = longint'(regs.image_width);
		span_h = longint'(regs.image_height);
		if (span_w > MAX_DIM) span_w = MAX_DIM;
		if (span_h > MAX_DIM) span_h = MAX_DIM;
		// Project the doubled centered offsets onto the direction
		proj = (2 * longint'(px) - span_w) * longint'($signed(regs.cos_a))
			+ (2 * longint'(py) - span_h) * longint'($signed(regs.sin_a));
		// Scale to a Q16 distance, floor rounding, then add one half and clamp
		distance = ((proj * longint'(regs.inv_span)) >>> 23) + longint'(DIST_HALF);
		if (distance < 0) distance = 0;
		if (distance > longint'(DIST_ONE)) distance = longint'(DIST_ONE);
		n = int'(regs.num_stops);
		if (n < 2) n = 2;
		if (n > MAX_STOPS) n = MAX_STOPS;
		scaled = distance * (n - 1);
		idx = int'(scaled >> 16);
		frac = scaled & 64'hFFFF;
		// Hold the last stop at full distance, else blend the two neighbors
		if (idx >= n - 1) begin
			mix = stop_color(n - 1);
		end else begin
			near = stop_color(idx);
			far = stop_color(idx + 1);
			for (int ch = 0; ch < 4; ch++) begin
				lo_c = longint'(near[8*ch +: 8]);
				hi_c = longint'(far[8*ch +: 8]);
				acc = lo_c * 65536 + frac * (hi_c - lo_c);
				mix[8*ch +: 8] = acc[23:16];
			end
		end
		c.x = px;
		c.y = py;
		c.red = mix[7:0];
		c.green = mix[15:8];
		c.blue = mix[23:16];
		c.alpha = mix[31:24];
		return c;
	endfunction

	// Compare the implemented bits of a register read with the tracked value
	function automatic bit readback_matches(input logic [2:0] idx, input logic [63:0] data);
		case (idx)
			REG_IMAGE_WIDTH:  return data[12:0] == regs.image_width;
			REG_IMAGE_HEIGHT: return data[12:0] == regs.image_height;
			REG_COS_A:        return data[15:0] == regs.cos_a;
			REG_SIN_A:        return data[15:0] == regs.sin_a;
			REG_INV_SPAN:     return data[23:0] == regs.inv_span;
			REG_NUM_STOPS:    return data[2:0] == regs.num_stops;
			REG_STOPS_LO:     return data == regs.stops_lo;
			REG_STOPS_HI:     return data == regs.stops_hi;
			default:          return 1'b1;
		endcase
	endfunction

	function automatic string describe(input pixel_color_t c);
		return $sformatf("x=%0d y=%0d r=%02h g=%02h b=%02h a=%02h",
			c.x, c.y, c.red, c.green, c.blue, c.alpha);
	endfunction

	// Count every fault, report only the first few
	task automatic note_fault(input string what);
		faults++;
		if (faults <= 10) $display("%0t ns gradient check: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_color_t want;
		pixel_color_t got;
		logic [2:0]   idx;
		if (!arst_n) begin
			regs.image_width = RST_IMAGE_WIDTH;
			regs.image_height = RST_IMAGE_HEIGHT;
			regs.cos_a = RST_COS_A;
			regs.sin_a = RST_SIN_A;
			regs.inv_span = RST_INV_SPAN;
			regs.num_stops = RST_NUM_STOPS;
			regs.stops_lo = '0;
			regs.stops_hi = '0;
			colors_due.delete();
		end else begin
			// Compare a returned color with the oldest prediction
			if (rgba.valid && rgba.ready) begin
				got = '{x: rgba.out_x, y: rgba.out_y, red: rgba.red, green: rgba.green,
					blue: rgba.blue, alpha: rgba.alpha};
				if (colors_due.size() == 0) begin
					note_fault({"color with no request outstanding: ", describe(got)});
				end else begin
					want = colors_due.pop_front();
					checked++;
					if (got.x !== want.x || got.y !== want.y || got.red !== want.red
							|| got.green !== want.green || got.blue !== want.blue
							|| got.alpha !== want.alpha) begin
						note_fault({"expected ", describe(want), ", got ", describe(got)});
					end
				end
			end
			// Predict the color of an accepted pixel request
			if (pix.valid && pix.ready) begin
				colors_due.push_back(gradient_color(pix.pix_x, pix.pix_y));
			end
			// Track register writes, check register reads
			if (psel && penable && pready) begin
				idx = paddr[LGP_IDX_LSB +: 3];
				if (pwrite) begin
					case (idx)
						REG_IMAGE_WIDTH:  regs.image_width = pwdata[12:0];
						REG_IMAGE_HEIGHT: regs.image_height = pwdata[12:0];
						REG_COS_A:        regs.cos_a = pwdata[15:0];
						REG_SIN_A:        regs.sin_a = pwdata[15:0];
						REG_INV_SPAN:     regs.inv_span = pwdata[23:0];
						REG_NUM_STOPS:    regs.num_stops = pwdata[2:0];
						REG_STOPS_LO:     regs.stops_lo = pwdata;
						REG_STOPS_HI:     regs.stops_hi = pwdata;
						default: ;
					endcase
				end else if (!readback_matches(idx, prdata)) begin
					note_fault($sformatf("register %0d read back as %016h", idx, prdata));
				end
			end
		end
		fault_count <= faults;
		colors_pending <= colors_due.size();
		colors_checked <= checked;
	end

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: linear gradient pixel generator
// Programs the gradient registers over APB, sends pixel requests under
// changing idle patterns, long output stalls and drain pauses, and leaves the
// prediction and comparison of every color to the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
	import lgp_pkg::*;

	localparam int PIPE_DEPTH   = 7;
	localparam int PHASES       = 9;
	localparam int PHASE_PIXELS = 56;
	localparam int STALL_CYCLES = 150;
	localparam int SPAN_FULL    = 11863283;
	localparam int RUN_LIMIT_NS = 4_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [LGP_ADDR_W-1:0] paddr;
	logic [LGP_DATA_W-1:0] pwdata;
	logic [LGP_DATA_W-1:0] prdata;
	logic                  pready;

	int send_idle_pct;
	int recv_idle_pct;
	int requests_sent;
	int settings_used;
	int fault_count;
	int colors_pending;
	int colors_checked;
	bit stall_req;

	lgp_pix_if  pix_if ();
	lgp_rgba_if rgba_if ();

	linear_gradient_pixel_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix_if),
		.rgba    (rgba_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	gradient_color_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.pix            (pix_if),
		.rgba           (rgba_if),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.fault_count    (fault_count),
		.colors_pending (colors_pending),
		.colors_checked (colors_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// End a hung run
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("[linear_gradient_pixel_top] ERROR");
		$finish;
	end

	// Drain results; drop ready at random, or for a long stretch on request
	initial begin : result_drain
		int stall_left;
		bit stall_seen;
		stall_left = 0;
		stall_seen = 1'b0;
		rgba_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rgba_if.ready <= 1'b0;
			end else if (stall_req != stall_seen) begin
				stall_seen = stall_req;
				stall_left = STALL_CYCLES - 1;
				rgba_if.ready <= 1'b0;
			end else begin
				rgba_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Write one register, then read it back for the checker
	task automatic set_reg(input logic [2:0] idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LGP_ADDR_W'(idx) << LGP_IDX_LSB;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_regs(input int w, input int h, input int cs, input int sn,
			input int span, input int stops, input logic [63:0] lo, input logic [63:0] hi);
		set_reg(REG_IMAGE_WIDTH, 64'(w));
		set_reg(REG_IMAGE_HEIGHT, 64'(h));
		set_reg(REG_COS_A, 64'(cs));
		set_reg(REG_SIN_A, 64'(sn));
		set_reg(REG_INV_SPAN, 64'(span));
		set_reg(REG_NUM_STOPS, 64'(stops));
		set_reg(REG_STOPS_LO, lo);
		set_reg(REG_STOPS_HI, hi);
		settings_used++;
	endtask

	// Offer one pixel request after a random gap and hold it until taken
	task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.pix_x <= x;
		pix_if.pix_y <= y;
		@(posedge clk);
		while (!pix_if.ready) @(posedge clk);
		requests_sent++;
	endtask

	// Stop sending and wait until every predicted color has come back
	task automatic drain();
		pix_if.valid <= 1'b0;
		@(posedge clk);
		while (colors_pending != 0) @(posedge clk);
	endtask

	// Drain, then let the pipeline empty before touching registers
	task automatic settle();
		drain();
		repeat (PIPE_DEPTH + 3) @(posedge clk);
	endtask

	initial begin : stimulus
		int w;
		int h;
		int w_eff;
		int h_eff;
		int cs;
		int sn;
		int span;
		int stops;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix_if.valid <= 1'b0;
		pix_if.pix_x <= '0;
		pix_if.pix_y <= '0;
		send_idle_pct = 35;
		recv_idle_pct = 79;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values
		send_pixel(12'd128, 12'd128);
		send_pixel(12'd4095, 12'd0);
		settle();

		// Horizontal gradient over four stops, corners and pixels off the image
		program_regs(256, 256, 16384, 0, 46341, 4, 64'hFF80_40FF_0000_00FF,
			64'h00FF_FF00_7F01_FE80);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd255, 12'd255);
		send_pixel(12'd128, 12'd128);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd64, 12'd17);
		send_pixel(12'd192, 12'd200);
		send_pixel(12'd100, 12'd7);
		settle();

		// Oversized image, stop count below two, full reciprocal, extreme direction
		program_regs(8191, 8191, -16384, 16384, SPAN_FULL, 0, 64'h0000_0000_FFFF_FFFF,
			64'hA5A5_5A5A_C3C3_3C3C);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd2048, 12'd2048);
		settle();

		// Zero reciprocal and stop count above the maximum
		program_regs(300, 200, 11585, 11585, 0, 7, 64'h1234_5678_9ABC_DEF0,
			64'h0F1E_2D3C_4B5A_6978);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd150, 12'd100);
		settle();

		// Unit image, three stops, smallest nonzero reciprocal
		program_regs(1, 1, 16384, -16384, 1, 3, 64'hFFFF_FFFF_0000_0000,
			64'h8080_8080_0102_0408);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		settle();

		// Random phases: receiver-idle then sender-idle heavy, then no idling
		for (int phase = 0; phase < PHASES; phase++) begin
			send_idle_pct = (phase < 3) ? 35 : (phase < 6) ? 79 : 0;
			recv_idle_pct = (phase < 3) ? 79 : (phase < 6) ? 35 : 0;
			w = $urandom_range(4096, 1);
			h = $urandom_range(4096, 1);
			if (phase == 2) begin
				w = 8191;
				h = 4097;
			end
			if (phase == 5) begin
				w = 1;
				h = 4096;
			end
			cs = int'($urandom_range(32768)) - 16384;
			sn = int'($urandom_range(32768)) - 16384;
			if (phase == 7) begin
				cs = 16384;
				sn = 16384;
			end
			if (phase == 8) begin
				cs = -16384;
				sn = -16384;
			end
			w_eff = (w > MAX_DIM) ? MAX_DIM : w;
			h_eff = (h > MAX_DIM) ? MAX_DIM : h;
			// Mostly a reciprocal that fits the width, sometimes any value
			if ($urandom_range(3) == 0) begin
				span = int'($urandom_range(24'hFF_FFFF));
			end else begin
				span = SPAN_FULL / w_eff + int'($urandom_range(64)) - 32;
			end
			if (phase == 4) span = SPAN_FULL;
			if (phase == 6) span = 0;
			stops = $urandom_range(7);
			if (phase == 0) stops = 2;
			if (phase == 1) stops = 3;
			if (phase == 3) stops = 4;
			program_regs(w, h, cs, sn, span, stops, {$urandom, $urandom}, {$urandom, $urandom});

			for (int k = 0; k < PHASE_PIXELS; k++) begin
				// Stall the output long enough to back up the pipeline
				if (k == 20 && (phase == 0 || phase == 6)) stall_req <= ~stall_req;
				// Pause the input until the pipeline is empty
				if (k == 30 && (phase == 3 || phase == 7)) drain();
				if ($urandom_range(3) != 0) begin
					send_pixel(12'($urandom_range(w_eff - 1)), 12'($urandom_range(h_eff - 1)));
				end else begin
					send_pixel(12'($urandom), 12'($urandom));
				end
			end
			settle();
		end

		$display("Sent %0d pixel requests over %0d register settings, %0d colors compared.",
			requests_sent, settings_used, colors_checked);
		$display("Covered stop counts in and out of range, unit and oversized images, zero %s",
			"and full reciprocals, long output stalls and full drains.");
		if (fault_count == 0 && colors_pending == 0) begin
			$display("[linear_gradient_pixel_top] OK");
		end else begin
			$display("[linear_gradient_pixel_top] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
